FILE: rtl/spq_pkg.sv
// Shared package for the stable priority queue.
// Holds the default sizes, the request and status codes, and the per-cell control struct.
// Depends on nothing.
`default_nettype none

package spq_pkg;

    // default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 8;
    localparam int TAG_WIDTH_DEF = 16;

    // request kind carried in s_tuser
    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_POP    = 1'b1
    } req_t;

    // result status carried in m_tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // operation broadcast to every cell in the chain
    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: holds a key and a tag.
// On insert it keeps, takes the new entry or takes its left neighbor; on pop it takes
// its right neighbor. Depends on spq_pkg.
`default_nettype none

module spq_cell #(
    parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
    input  wire logic                   aclk,
    input  wire spq_pkg::cell_ctrl_t    ctrl,
    input  wire logic [KEY_WIDTH-1:0]   new_key,
    input  wire logic [TAG_WIDTH-1:0]   new_tag,
    input  wire logic                   occupied,
    input  wire logic                   left_keep,
    input  wire logic [KEY_WIDTH-1:0]   left_key,
    input  wire logic [TAG_WIDTH-1:0]   left_tag,
    input  wire logic [KEY_WIDTH-1:0]   right_key,
    input  wire logic [TAG_WIDTH-1:0]   right_tag,
    output logic                        keep,
    output logic [KEY_WIDTH-1:0]        key,
    output logic [TAG_WIDTH-1:0]        tag
);
    import spq_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [TAG_WIDTH-1:0] tag_reg, tag_next;

    // stored entry stays ahead of a new one with equal or higher urgency value
    assign keep = occupied && (key_reg <= new_key);
    assign key  = key_reg;
    assign tag  = tag_reg;

    // slot update
    always_comb begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                if (left_keep) begin
                    key_next = new_key;
                    tag_next = new_tag;
                end else begin
                    key_next = left_key;
                    tag_next = left_tag;
                end
            end
        end else if (ctrl.pop) begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

FILE: rtl/stable_priority_queue.sv
// Stable priority queue: a chain of DEPTH cells kept sorted by ascending urgency.
// A result item appears on m_* in the cycle after its request item is accepted.
// Throughput: one item per cycle while m_tready stays high; a waiting result holds
// s_tready low, and the next item is taken in the cycle that result leaves.
// Reset (aresetn low, synchronous): the queue is emptied and no result is pending.
// Depends on spq_pkg and spq_cell; slot contents are not reset.
`default_nettype none

module stable_priority_queue #(
    parameter int DEPTH     = spq_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = spq_pkg::KEY_WIDTH_DEF,
    parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int S_DW     = ((KEY_WIDTH + TAG_WIDTH + 7) / 8) * 8,
    localparam int M_DW     = ((KEY_WIDTH + TAG_WIDTH + CNT_W + 1 + 7) / 8) * 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // request items
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [S_DW-1:0] s_tdata,   // urgency, tag
    input  wire logic [0:0]      s_tuser,   // req_type
    // result items
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [M_DW-1:0]      m_tdata,   // out_urgency, out_tag, occupancy, is_empty
    output logic [7:0]           m_tuser    // status, out_valid
);
    import spq_pkg::*;

    // request fields
    logic                 accept;
    req_t                 req;
    logic [KEY_WIDTH-1:0] in_key;
    logic [TAG_WIDTH-1:0] in_tag;

    assign accept = s_tvalid && s_tready;
    assign req    = req_t'(s_tuser[0]);
    assign in_key = s_tdata[KEY_WIDTH-1:0];
    assign in_tag = s_tdata[KEY_WIDTH+TAG_WIDTH-1:KEY_WIDTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic             full, empty;
    cell_ctrl_t       ctrl;
    status_t          status;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // decide the chain operation and the new fill count
    always_comb begin
        ctrl       = '0;
        status     = ST_OK;
        count_next = count_reg;
        if (accept) begin
            case (req)
                REQ_INSERT: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                REQ_POP: begin
                    if (empty) begin
                        status = ST_EMPTY;
                    end else begin
                        ctrl.pop   = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // chain of cells
    logic                 keep_w [DEPTH];
    logic [KEY_WIDTH-1:0] key_w  [DEPTH];
    logic [TAG_WIDTH-1:0] tag_w  [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 occ;
        logic                 lkeep;
        logic [KEY_WIDTH-1:0] lkey, rkey;
        logic [TAG_WIDTH-1:0] ltag, rtag;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign lkeep = 1'b1;
            assign lkey  = in_key;
            assign ltag  = in_tag;
        end else begin : g_mid
            assign lkeep = keep_w[i-1];
            assign lkey  = key_w[i-1];
            assign ltag  = tag_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign rkey = key_w[i];
            assign rtag = tag_w[i];
        end else begin : g_inner
            assign rkey = key_w[i+1];
            assign rtag = tag_w[i+1];
        end

        spq_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .TAG_WIDTH (TAG_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .new_key   (in_key),
            .new_tag   (in_tag),
            .occupied  (occ),
            .left_keep (lkeep),
            .left_key  (lkey),
            .left_tag  (ltag),
            .right_key (rkey),
            .right_tag (rtag),
            .keep      (keep_w[i]),
            .key       (key_w[i]),
            .tag       (tag_w[i])
        );
    end

    // result register
    logic                 rvalid_reg;
    status_t              rstatus_reg;
    logic                 rpop_reg;
    logic [KEY_WIDTH-1:0] rkey_reg;
    logic [TAG_WIDTH-1:0] rtag_reg;
    logic [CNT_W-1:0]     rocc_reg;

    assign s_tready = !rvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rvalid_reg <= 1'b0;
        end else if (accept) begin
            rvalid_reg <= 1'b1;
        end else if (m_tready) begin
            rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rstatus_reg <= status;
            rpop_reg    <= ctrl.pop;
            rkey_reg    <= ctrl.pop ? key_w[0] : '0;
            rtag_reg    <= ctrl.pop ? tag_w[0] : '0;
            rocc_reg    <= count_next;
        end
    end

    // pack the result item
    always_comb begin
        m_tdata = '0;
        m_tdata[KEY_WIDTH-1:0]                   = rkey_reg;
        m_tdata[KEY_WIDTH+TAG_WIDTH-1:KEY_WIDTH] = rtag_reg;
        m_tdata[KEY_WIDTH+TAG_WIDTH+CNT_W-1:KEY_WIDTH+TAG_WIDTH] = rocc_reg;
        m_tdata[KEY_WIDTH+TAG_WIDTH+CNT_W]       = (rocc_reg == '0);
        m_tuser      = '0;
        m_tuser[1:0] = rstatus_reg;
        m_tuser[2]   = rpop_reg;
    end

    assign m_tvalid = rvalid_reg;

endmodule

`default_nettype wire
